/* rtl/core/tomq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tomq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int TIME_W    = 63;
    localparam int HANDLER_W = 16;
    localparam int CODE_W    = 32;
    localparam int OBJ_W     = 32;

    typedef enum logic [1:0] {
        OP_ENQ   = 2'd0,
        OP_POP   = 2'd1,
        OP_QUERY = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic [TIME_W-1:0]    when_time;
        logic [HANDLER_W-1:0] handler;
        logic [CODE_W-1:0]    code;
        logic [OBJ_W-1:0]     obj;
    } msg_t;

    typedef struct packed {
        logic valid;
        msg_t msg;
    } entry_t;

    // Broadcast from the top level to every cell
    typedef struct packed {
        logic enq;
        logic pop;
        msg_t msg;
    } cell_cmd_t;

endpackage

`default_nettype wire

/* rtl/core/time_ordered_message_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

// Sorted message queue built as a row of QUEUE_DEPTH cells, head in cell 0.
// Every request (enqueue, pop, query) is accepted at once: busy stays low,
// so a new request may be issued in every cycle. Its result appears on the
// result ports with done high in the cycle after the request, for one
// cycle only; the receiver cannot stall, so it must capture the result then.
// All cells compare against the broadcast request in parallel and each moves
// its entry to or from a neighbor in that same cycle, which sets the rate.
// An enqueue into a full queue is dropped with status full; a pop of an empty
// queue returns status empty and zero fields.

module time_ordered_message_queue
    import tomq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               op,
    input  logic [TIME_W-1:0]        when_time,
    input  logic [HANDLER_W-1:0]     handler_id,
    input  logic signed [CODE_W-1:0] what_code,
    input  logic [OBJ_W-1:0]         obj_tag,
    output logic                     done,
    output logic [1:0]               status,
    output logic                     found,
    output logic [TIME_W-1:0]        out_when,
    output logic [HANDLER_W-1:0]     out_handler,
    output logic signed [CODE_W-1:0] out_what,
    output logic [OBJ_W-1:0]         out_obj
);

    cell_cmd_t                cmd;
    entry_t                   cell_entry [QUEUE_DEPTH];
    entry_t                   prev_e     [QUEUE_DEPTH];
    entry_t                   next_e     [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]   keep_vec;
    logic [QUEUE_DEPTH-1:0]   prev_keep;
    logic [QUEUE_DEPTH-1:0]   match_vec;

    logic                     full;
    logic                     empty;
    logic                     is_enq;
    logic                     is_pop;
    logic                     is_query;

    logic                     done_reg;
    logic [1:0]               status_reg;
    logic [1:0]               status_next;
    logic                     found_reg;
    logic                     found_next;
    msg_t                     out_msg_reg;
    msg_t                     out_msg_next;

    assign busy = 1'b0;

    assign full  = cell_entry[QUEUE_DEPTH-1].valid;
    assign empty = !cell_entry[0].valid;

    assign is_enq   = start && (op == OP_ENQ);
    assign is_pop   = start && (op == OP_POP);
    assign is_query = start && (op == OP_QUERY);

    assign cmd.enq           = is_enq && !full;
    assign cmd.pop           = is_pop && !empty;
    assign cmd.msg.when_time = when_time;
    assign cmd.msg.handler   = handler_id;
    assign cmd.msg.code      = what_code;
    assign cmd.msg.obj       = obj_tag;

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                // The head slot takes the new message unless it keeps its own
                assign prev_e[gi]    = '0;
                assign prev_keep[gi] = 1'b1;
            end
            else
            begin : g_body
                assign prev_e[gi]    = cell_entry[gi-1];
                assign prev_keep[gi] = keep_vec[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1)
            begin : g_tail
                assign next_e[gi] = '0;
            end
            else
            begin : g_mid
                assign next_e[gi] = cell_entry[gi+1];
            end

            tomq_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .prev_entry (prev_e[gi]),
                .prev_keep  (prev_keep[gi]),
                .next_entry (next_e[gi]),
                .entry      (cell_entry[gi]),
                .keep       (keep_vec[gi]),
                .match      (match_vec[gi])
            );
        end
    endgenerate

    always_comb
    begin
        status_next  = STAT_DONE;
        found_next   = 1'b0;
        out_msg_next = '0;
        if (is_enq && full)
        begin
            status_next = STAT_FULL;
        end
        else if (is_pop)
        begin
            if (empty)
            begin
                status_next = STAT_EMPTY;
            end
            else
            begin
                out_msg_next = cell_entry[0].msg;
            end
        end
        else if (is_query)
        begin
            // A null handler never matches
            found_next = (handler_id != '0) && (|match_vec);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        found_reg   <= found_next;
        out_msg_reg <= out_msg_next;
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign found       = found_reg;
    assign out_when    = out_msg_reg.when_time;
    assign out_handler = out_msg_reg.handler;
    assign out_what    = out_msg_reg.code;
    assign out_obj     = out_msg_reg.obj;

endmodule

`default_nettype wire

/* rtl/core/tomq_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module tomq_cell
    import tomq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_cmd_t cmd,
    input  entry_t    prev_entry,
    input  logic      prev_keep,
    input  entry_t    next_entry,
    output entry_t    entry,
    output logic      keep,
    output logic      match
);

    logic valid_reg;
    logic valid_next;
    msg_t msg_reg;
    msg_t msg_next;

    assign entry.valid = valid_reg;
    assign entry.msg   = msg_reg;

    // Entries at or before the new time stay put; the rest shift toward the tail
    assign keep = valid_reg && (msg_reg.when_time <= cmd.msg.when_time);

    assign match = valid_reg
                && (msg_reg.handler == cmd.msg.handler)
                && (msg_reg.code == cmd.msg.code)
                && ((cmd.msg.obj == '0) || (msg_reg.obj == cmd.msg.obj));

    always_comb
    begin
        valid_next = valid_reg;
        msg_next   = msg_reg;
        if (cmd.enq)
        begin
            if (!keep)
            begin
                if (prev_keep)
                begin
                    valid_next = 1'b1;
                    msg_next   = cmd.msg;
                end
                else
                begin
                    valid_next = prev_entry.valid;
                    msg_next   = prev_entry.msg;
                end
            end
        end
        else if (cmd.pop)
        begin
            valid_next = next_entry.valid;
            msg_next   = next_entry.msg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        msg_reg <= msg_next;
    end

endmodule

`default_nettype wire

/* rtl/core/tomq_chk.sv */
`timescale 1ns / 1ps
`default_nettype none

module tomq_chk
    import tomq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     busy,
    input  logic [1:0]               op,
    input  logic                     done,
    input  logic [1:0]               status,
    input  logic                     found,
    input  logic [TIME_W-1:0]        out_when,
    input  logic [HANDLER_W-1:0]     out_handler,
    input  logic signed [CODE_W-1:0] out_what,
    input  logic [OBJ_W-1:0]         out_obj
);

    // Every accepted request yields exactly one result in the next cycle
    a_req_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("accepted request produced no result");

    a_result_has_req: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy))
        else $error("result without a request");

    // Status codes follow the operation that was issued
    a_status_matches_op: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (op != OP_ENQ) && (op != OP_POP)) |=> (status == STAT_DONE))
        else $error("query or no-op reported a failure status");

    a_found_only_query: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (op != OP_QUERY)) |=> !found)
        else $error("found raised on a non-query request");

    a_fail_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != STAT_DONE)) |->
            (out_when == '0) && (out_handler == '0) && (out_what == '0) && (out_obj == '0))
        else $error("failed request returned message fields");

endmodule

bind time_ordered_message_queue tomq_chk u_tomq_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .op          (op),
    .done        (done),
    .status      (status),
    .found       (found),
    .out_when    (out_when),
    .out_handler (out_handler),
    .out_what    (out_what),
    .out_obj     (out_obj)
);

`default_nettype wire

/* tb/time_ordered_message_queue_tb.sv */
`timescale 1ns / 1ps

module time_ordered_message_queue_tb;
    import tomq_pkg::*;

    localparam int DEPTH = QUEUE_DEPTH_DEF;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    localparam int DRAIN_LIMIT = 200;
    localparam int SETTLE_CYCLES = 10;

    typedef struct packed {
        status_t status;
        logic    found;
        msg_t    msg;
    } outcome_t;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [1:0]               op;
    logic [TIME_W-1:0]        when_time;
    logic [HANDLER_W-1:0]     handler_id;
    logic signed [CODE_W-1:0] what_code;
    logic [OBJ_W-1:0]         obj_tag;
    logic                     done;
    logic [1:0]               status;
    logic                     found;
    logic [TIME_W-1:0]        out_when;
    logic [HANDLER_W-1:0]     out_handler;
    logic signed [CODE_W-1:0] out_what;
    logic [OBJ_W-1:0]         out_obj;

    msg_t     queued_msgs[$];
    outcome_t pending_outcomes[$];

    int  error_count = 0;
    int  n_enq = 0;
    int  n_pop = 0;
    int  n_query = 0;
    int  n_dropped = 0;
    int  n_empty_pops = 0;
    int  n_hits = 0;
    int  drain_wait;
    bit  gaps_on = 1'b0;

    time_ordered_message_queue #(
        .QUEUE_DEPTH(DEPTH)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .op         (op),
        .when_time  (when_time),
        .handler_id (handler_id),
        .what_code  (what_code),
        .obj_tag    (obj_tag),
        .done       (done),
        .status     (status),
        .found      (found),
        .out_when   (out_when),
        .out_handler(out_handler),
        .out_what   (out_what),
        .out_obj    (out_obj)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Apply one request to the sorted message list and return its outcome
    function automatic outcome_t apply_request(logic [1:0] req_op, msg_t m);
        outcome_t r;
        int pos;
        r = '0;
        r.status = STAT_DONE;
        case (req_op)
            OP_ENQ:
            begin
                if (queued_msgs.size() >= DEPTH)
                    r.status = STAT_FULL;
                else
                begin
                    // insert after every entry due at or before this one
                    pos = 0;
                    while (pos < queued_msgs.size() && queued_msgs[pos].when_time <= m.when_time)
                        pos++;
                    queued_msgs.insert(pos, m);
                end
            end
            OP_POP:
            begin
                if (queued_msgs.size() == 0)
                    r.status = STAT_EMPTY;
                else
                    r.msg = queued_msgs.pop_front();
            end
            OP_QUERY:
            begin
                if (m.handler != '0)
                begin
                    foreach (queued_msgs[i])
                    begin
                        if (queued_msgs[i].handler == m.handler && queued_msgs[i].code == m.code
                            && (m.obj == '0 || queued_msgs[i].obj == m.obj))
                            r.found = 1'b1;
                    end
                end
            end
            default:
                ;
        endcase
        return r;
    endfunction

    function automatic void compare_field(string name, logic [TIME_W-1:0] want,
                                          logic [TIME_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        outcome_t e;
        if (rst_n && done === 1'b1)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $error("result strobe with no request outstanding");
                error_count++;
            end
            else
            begin
                e = pending_outcomes.pop_front();
                compare_field("status", TIME_W'(e.status), TIME_W'(status));
                compare_field("found", TIME_W'(e.found), TIME_W'(found));
                compare_field("out_when", e.msg.when_time, out_when);
                compare_field("out_handler", TIME_W'(e.msg.handler), TIME_W'(out_handler));
                compare_field("out_what", TIME_W'(e.msg.code), TIME_W'($unsigned(out_what)));
                compare_field("out_obj", TIME_W'(e.msg.obj), TIME_W'(out_obj));
            end
        end
    end

    // Called at a rising edge; returns at the edge that accepts the request
    task automatic send_request(logic [1:0] req_op, logic [TIME_W-1:0] t,
                                logic [HANDLER_W-1:0] h, logic [CODE_W-1:0] c,
                                logic [OBJ_W-1:0] o);
        msg_t     m;
        outcome_t r;
        int       gap;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 3);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        op <= req_op;
        when_time <= t;
        handler_id <= h;
        what_code <= c;
        obj_tag <= o;
        start <= 1'b1;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        m.when_time = t;
        m.handler = h;
        m.code = c;
        m.obj = o;
        r = apply_request(req_op, m);
        pending_outcomes.push_back(r);
        case (req_op)
            OP_ENQ:   n_enq++;
            OP_POP:   n_pop++;
            OP_QUERY: n_query++;
            default:  ;
        endcase
        if (r.status == STAT_FULL)
            n_dropped++;
        if (r.status == STAT_EMPTY)
            n_empty_pops++;
        if (r.found)
            n_hits++;
    endtask

    function automatic logic [TIME_W-1:0] random_time();
        case ($urandom_range(0, 9))
            0:       return TIME_W'({$urandom, $urandom});
            1:       return TIME_MAX - TIME_W'($urandom_range(0, 3));
            default: return TIME_W'($urandom_range(0, 40));
        endcase
    endfunction

    function automatic logic [HANDLER_W-1:0] random_handler();
        case ($urandom_range(0, 7))
            0:       return HANDLER_W'($urandom);
            1:       return '0;
            default: return HANDLER_W'($urandom_range(1, 4));
        endcase
    endfunction

    function automatic logic [CODE_W-1:0] random_code();
        case ($urandom_range(0, 7))
            0:       return $urandom;
            1:       return 32'h8000_0000;
            2:       return 32'h7FFF_FFFF;
            default: return $urandom_range(0, 4) - 2;
        endcase
    endfunction

    function automatic logic [OBJ_W-1:0] random_obj();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return $urandom;
            default: return $urandom_range(1, 3);
        endcase
    endfunction

    // Aim most queries at a stored message, some with near-miss fields
    task automatic send_query();
        msg_t             target;
        logic [OBJ_W-1:0] o;
        if (queued_msgs.size() > 0 && $urandom_range(0, 2) != 0)
        begin
            target = queued_msgs[$urandom_range(0, queued_msgs.size() - 1)];
            case ($urandom_range(0, 3))
                0: o = '0;
                1: o = target.obj;
                2: o = target.obj + 1;
                default:
                begin
                    o = target.obj;
                    target.code = target.code ^ 1;
                end
            endcase
            send_request(OP_QUERY, random_time(), target.handler, target.code, o);
        end
        else
            send_request(OP_QUERY, random_time(), random_handler(), random_code(), random_obj());
    endtask

    task automatic test_field_extremes();
        send_request(OP_ENQ, TIME_MAX, 16'hFFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        send_request(OP_ENQ, '0, '0, 32'h7FFF_FFFF, '0);
        // null handler query never matches, even a stored null-handler message
        send_request(OP_QUERY, '0, '0, 32'h7FFF_FFFF, '0);
        send_request(OP_QUERY, '0, 16'hFFFF, 32'h8000_0000, '0);
        send_request(OP_QUERY, TIME_MAX, 16'hFFFF, 32'h8000_0000, 32'hFFFF_FFFE);
        send_request(OP_POP, '0, '0, '0, '0);
        send_request(OP_POP, TIME_MAX, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_POP, '0, '0, '0, '0);
        send_request(OP_UNUSED, TIME_MAX, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    // Fill with repeated due times, then push one more into the full queue
    task automatic test_fill_to_full();
        for (int i = 0; i <= DEPTH; i++)
            send_request(OP_ENQ, TIME_W'((i * 7) % 4), HANDLER_W'(i + 1), CODE_W'(i),
                         OBJ_W'(i));
    endtask

    task automatic test_random_traffic(int count, bit allow_gaps);
        int enq_pct;
        int pick;
        enq_pct = 50;
        for (int i = 0; i < count; i++)
        begin
            // shift the mix now and then so the queue swings between full and empty
            if (i % 60 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       enq_pct = 75;
                    1:       enq_pct = 25;
                    default: enq_pct = 50;
                endcase
                gaps_on = allow_gaps && ($urandom_range(0, 2) != 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 2)
                send_request(OP_UNUSED, random_time(), random_handler(), random_code(),
                             random_obj());
            else if (pick < 27)
                send_query();
            else if ($urandom_range(0, 99) < enq_pct)
                send_request(OP_ENQ, random_time(), random_handler(), random_code(),
                             random_obj());
            else
                send_request(OP_POP, random_time(), random_handler(), random_code(),
                             random_obj());
        end
        gaps_on = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        op = OP_ENQ;
        when_time = '0;
        handler_id = '0;
        what_code = '0;
        obj_tag = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_field_extremes();
        test_fill_to_full();
        test_random_traffic(1600, 1'b1);
        // close with back-to-back requests, no gaps
        test_random_traffic(200, 1'b0);

        start <= 1'b0;
        drain_wait = 0;
        while (pending_outcomes.size() > 0 && drain_wait < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_wait++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_outcomes.size() > 0)
        begin
            $error("%0d results never arrived", pending_outcomes.size());
            error_count++;
        end

        $display("Covered %0d enqueues (%0d dropped on full), %0d pops (%0d on empty),",
                 n_enq, n_dropped, n_pop, n_empty_pops);
        $display("and %0d queries with %0d hits; %0d mismatches seen.",
                 n_query, n_hits, error_count);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
